>>> rtl/dbe_pkg.sv
// Shared types, constants and field helpers for the debounce event block.
package dbe_pkg;

  localparam int NumChannelsDef = 5;
  localparam int MaxEvents      = 3;
  localparam int QueueDepth     = 4;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int PinW     = 5;
  localparam int CodeW    = 4;
  localparam int ChanW    = 3;
  localparam int DebW     = 8;
  localparam int CountsW  = 20;
  localparam int CodesW   = 60;
  localparam int ListW    = 12;
  localparam int CntW     = 2;

  localparam logic [CfgIdxW-1:0] RegDebounce  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPressed   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCounts    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDownCodes = 3'd3;
  localparam logic [CfgIdxW-1:0] RegUpCodes   = 3'd4;

  localparam logic [DebW-1:0]    DebounceReset = 8'd50;
  localparam logic [CountsW-1:0] CountsReset   = 20'd328030;

  typedef struct packed {
    logic [DebW-1:0]    debounce_ticks;
    logic [PinW-1:0]    pressed_levels;
    logic [CountsW-1:0] event_counts;
    logic [CodesW-1:0]  down_event_codes;
    logic [CodesW-1:0]  up_event_codes;
  } dbe_cfg_t;

  // One settled channel with a nonempty event list.
  typedef struct packed {
    logic [ListW-1:0] codes;
    logic [CntW-1:0]  cnt;
    logic [ChanW-1:0] chan;
    logic             went_down;
    logic             last;
  } dbe_job_t;

  // Two-bit count at a bit position; bits past the register read as zero.
  function automatic logic [CntW-1:0] count_at(input logic [CountsW-1:0] counts,
                                               input logic [5:0] pos);
    logic [63:0] w;
    w = {{(64-CountsW){1'b0}}, counts} >> pos;
    return w[CntW-1:0];
  endfunction

  // Three code slots of one channel; bits past the register read as zero.
  function automatic logic [ListW-1:0] list_at(input logic [CodesW-1:0] codes,
                                               input logic [7:0] pos);
    logic [63:0] w;
    w = {{(64-CodesW){1'b0}}, codes} >> pos;
    return w[ListW-1:0];
  endfunction

endpackage

>>> rtl/dbe_fifo.sv
// Short job queue between the channel scanner and the event emitter.
module dbe_fifo #(
  parameter int DEPTH = dbe_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dbe_pkg::dbe_job_t wdata,
  output logic              full,
  input  logic              pop,
  output dbe_pkg::dbe_job_t rdata,
  output logic              empty
);
  import dbe_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  dbe_job_t            mem [DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/dbe_front.sv
// Channel scanner: steps each channel's debounce machine once per tick and queues settlings.
module dbe_front #(
  parameter int NUM_CHANNELS = dbe_pkg::NumChannelsDef
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dbe_pkg::dbe_cfg_t          cfg,
  input  logic                       push,
  input  logic [dbe_pkg::PinW-1:0]   pin_levels,
  output logic                       full,
  output logic                       q_push,
  output dbe_pkg::dbe_job_t          q_wdata,
  input  logic                       q_full
);
  import dbe_pkg::*;

  localparam int IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  localparam logic [1:0] PH_UP      = 2'd0;
  localparam logic [1:0] PH_FALLING = 2'd1;
  localparam logic [1:0] PH_DOWN    = 2'd2;
  localparam logic [1:0] PH_RISING  = 2'd3;

  logic [1:0]      state;
  logic [IdxW-1:0] idx;
  logic [PinW-1:0] pins;
  logic            pend_valid;
  dbe_job_t        pend;
  logic [1:0]      phase     [NUM_CHANNELS];
  logic [DebW-1:0] countdown [NUM_CHANNELS];

  logic [1:0]      ph;
  logic [DebW-1:0] cd;
  logic [15:0]     level_w;
  logic [15:0]     want_w;
  logic            pressed;
  logic            settle;
  logic [CntW-1:0] cnt_raw;
  logic [CntW-1:0] cnt_cl;
  logic            emit;
  logic            stall;
  logic [1:0]      phase_next;
  logic [DebW-1:0] countdown_next;
  dbe_job_t        job;

  always_comb begin
    ph      = phase[idx];
    cd      = countdown[idx];
    level_w = 16'(pins) >> idx;
    want_w  = 16'(cfg.pressed_levels) >> idx;
    pressed = (level_w[0] == want_w[0]);
    settle  = ((ph == PH_FALLING) || (ph == PH_RISING)) && (cd == '0);
    cnt_raw = pressed ? count_at(cfg.event_counts, 6'(6'(idx) << 1))
                      : count_at(cfg.event_counts, 6'(6'd10 + 6'(6'(idx) << 1)));
    cnt_cl  = (cnt_raw > CntW'(MaxEvents)) ? CntW'(MaxEvents) : cnt_raw;
    emit    = settle && (cnt_cl != '0);
    // Hold a channel with events to queue while the previous job cannot leave.
    stall   = emit && pend_valid && q_full;

    job.codes     = list_at(pressed ? cfg.down_event_codes : cfg.up_event_codes,
                            8'(8'(idx) * 8'd12));
    job.cnt       = cnt_cl;
    job.chan      = ChanW'(idx);
    job.went_down = pressed;
    job.last      = 1'b0;

    phase_next     = ph;
    countdown_next = cd;
    unique case (ph)
      PH_UP: begin
        if (pressed) begin
          phase_next     = PH_FALLING;
          countdown_next = cfg.debounce_ticks;
        end
      end
      PH_DOWN: begin
        if (!pressed) begin
          phase_next     = PH_RISING;
          countdown_next = cfg.debounce_ticks;
        end
      end
      default: begin
        if (cd != '0) begin
          countdown_next = cd - 1'b1;
        end else begin
          phase_next = pressed ? PH_DOWN : PH_UP;
        end
      end
    endcase

    q_wdata      = pend;
    q_wdata.last = (state == ST_FLUSH);
    q_push       = 1'b0;
    if (state == ST_SCAN) begin
      q_push = emit && pend_valid && !q_full;
    end else if (state == ST_FLUSH) begin
      q_push = pend_valid && !q_full;
    end
  end

  assign full = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      pend_valid <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        phase[i]     <= PH_UP;
        countdown[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (push) begin
            pins  <= pin_levels;
            idx   <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!stall) begin
            phase[idx]     <= phase_next;
            countdown[idx] <= countdown_next;
            // Keep the newest job back so the tick's final one can be marked.
            if (emit) begin
              pend       <= job;
              pend_valid <= 1'b1;
            end
            if (idx == IdxW'(NUM_CHANNELS - 1)) begin
              state <= ST_FLUSH;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid || !q_full) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/dbe_back.sv
// Event emitter: expands queued jobs into codes, one per cycle while popped.
module dbe_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  dbe_pkg::dbe_job_t         q_rdata,
  output logic                      q_pop,
  output logic                      empty,
  input  logic                      pop,
  output logic [dbe_pkg::CodeW-1:0] event_code,
  output logic [dbe_pkg::ChanW-1:0] channel,
  output logic                      went_down,
  output logic                      last
);
  import dbe_pkg::*;

  logic            out_valid;
  logic [CntW-1:0] slot;
  logic            load;
  logic            slot_end;
  logic [ListW-1:0] slot_codes;

  assign empty      = !out_valid;
  assign load       = !q_empty && (!out_valid || pop);
  assign slot_end   = (slot == q_rdata.cnt - 1'b1);
  assign slot_codes = q_rdata.codes >> {slot, 2'b00};
  assign q_pop      = load && slot_end;

  always_ff @(posedge clk) begin
    if (load) begin
      event_code <= slot_codes[CodeW-1:0];
      channel    <= q_rdata.chan;
      went_down  <= q_rdata.went_down;
      last       <= q_rdata.last && slot_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      slot      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        slot      <= slot_end ? '0 : slot + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/multi_channel_debounce_events_top.sv
// Top level: configuration registers, channel scanner, job queue and event emitter.
//
//   channel   direction  handshake            payload
//   tick      in         push / full          pin_levels
//   events    out        pop / empty          event_code, channel, went_down, last
//   config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A tick holds full from its transfer until the scanner is idle again: one channel's
// debounce machine steps per cycle unless the scanner stalls, then the final job is handed
// off. Events leave one per cycle from the emitter's output register while popped.
// The scanner stalls on a settling channel only when the job queue is full.
// Reset returns every channel to up with a zero countdown and loads register defaults.
module multi_channel_debounce_events_top #(
  parameter int NUM_CHANNELS = dbe_pkg::NumChannelsDef
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [dbe_pkg::PinW-1:0]     pin_levels,
  output logic                         empty,
  input  logic                         pop,
  output logic [dbe_pkg::CodeW-1:0]    event_code,
  output logic [dbe_pkg::ChanW-1:0]    channel,
  output logic                         went_down,
  output logic                         last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dbe_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [dbe_pkg::CfgDataW-1:0] cfg_data
);
  import dbe_pkg::*;

  dbe_cfg_t cfg;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  dbe_job_t q_wdata;
  dbe_job_t q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= DebounceReset;
      cfg.pressed_levels   <= '0;
      cfg.event_counts     <= CountsReset;
      cfg.down_event_codes <= '0;
      cfg.up_event_codes   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegDebounce:  cfg.debounce_ticks   <= cfg_data[DebW-1:0];
        RegPressed:   cfg.pressed_levels   <= cfg_data[PinW-1:0];
        RegCounts:    cfg.event_counts     <= cfg_data[CountsW-1:0];
        RegDownCodes: cfg.down_event_codes <= cfg_data[CodesW-1:0];
        RegUpCodes:   cfg.up_event_codes   <= cfg_data[CodesW-1:0];
        default: begin
          // Drop writes to unknown indexes.
        end
      endcase
    end
  end

  dbe_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .pin_levels (pin_levels),
    .full       (full),
    .q_push     (q_push),
    .q_wdata    (q_wdata),
    .q_full     (q_full)
  );

  dbe_fifo #(
    .DEPTH(QueueDepth)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  dbe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .event_code (event_code),
    .channel    (channel),
    .went_down  (went_down),
    .last       (last)
  );

endmodule

>>> rtl/dbe_checker.sv
// Port-level checks for the debounce event block, bound to the top level.
module dbe_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         push,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic [dbe_pkg::CodeW-1:0]    event_code,
  input logic [dbe_pkg::ChanW-1:0]    channel,
  input logic                         went_down,
  input logic                         last,
  input logic                         cfg_ready
);

  // Reset leaves no event waiting and the tick side open.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("block not idle after reset");

  // A tick keeps the scanner busy for at least the following cycle.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("full not raised after tick transfer");

  // A waiting event holds until its transfer.
  a_event_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(event_code) && $stable(channel)
                          && $stable(went_down) && $stable(last)))
    else $error("waiting event changed before transfer");

  // Configuration writes are never refused outside reset.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind multi_channel_debounce_events_top dbe_checker u_dbe_checker (
  .clk        (clk),
  .rst        (rst),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .event_code (event_code),
  .channel    (channel),
  .went_down  (went_down),
  .last       (last),
  .cfg_ready  (cfg_ready)
);

>>> verif/multi_channel_debounce_events_top_tb.sv
// Self-checking testbench for the five-channel switch debounce event block.
module multi_channel_debounce_events_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dbe_pkg::*;

  localparam int NCH            = NumChannelsDef;
  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 12;
  localparam int DRAIN_SLACK    = 3 * (NCH + 2) + 10;
  localparam int DRAIN_LIMIT    = 30000;
  localparam int LONG_HOLD      = 400;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_TICKS    = 38;
  localparam int TIMEOUT_CYCLES = 1000000;
  localparam int MAX_REPORTS    = 40;

  // Index values that decode to no register.
  localparam logic [CfgIdxW-1:0] RegSpare5 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSpare7 = 3'd7;

  typedef enum logic [1:0] {SW_UP, SW_FALLING, SW_DOWN, SW_RISING} sw_phase_e;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [ChanW-1:0] chan;
    logic             went_down;
    logic             last;
  } settle_event_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  // quiet marks a tick whose debounce step cannot emit anything
  typedef struct {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    logic [PinW-1:0]      pins;
    bit                   quiet;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                push;
  logic                full;
  logic [PinW-1:0]     pin_levels;
  logic                empty;
  logic                pop;
  logic [CodeW-1:0]    event_code;
  logic [ChanW-1:0]    channel;
  logic                went_down;
  logic                last;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  dbe_cfg_t        model_cfg;
  sw_phase_e       chan_phase [NCH];
  logic [DebW-1:0] chan_count [NCH];
  settle_event_t   expected_events [$];

  int  fail_count   = 0;
  int  ticks_sent   = 0;
  int  events_seen  = 0;
  int  cfg_writes   = 0;
  int  down_settles = 0;
  int  up_settles   = 0;
  bit  drain_hold   = 1'b0;
  bit  rx_eager     = 1'b0;

  // pressed = all channels at the pressed level for pressed_levels = 5'h0A
  stim_row_t dir_table [0:32] = '{
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h1F, 1'b1},
    '{ROW_CFG,  RegDebounce,  64'hFFFF_FFFF_FFFF_FF00, 5'h00, 1'b0},
    '{ROW_CFG,  RegPressed,   64'hFFFF_FFFF_FFFF_FFEA, 5'h00, 1'b0},
    '{ROW_CFG,  RegCounts,    64'hFFFF_FFFF_FFFF_FFFF, 5'h00, 1'b0},
    '{ROW_CFG,  RegDownCodes, 64'hF123_4567_89AB_CDEF, 5'h00, 1'b0},
    '{ROW_CFG,  RegUpCodes,   64'h0FED_CBA9_8765_4321, 5'h00, 1'b0},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h0A, 1'b1},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h0A, 1'b0},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h15, 1'b1},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h15, 1'b0},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h0A, 1'b1},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h15, 1'b0},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h0A, 1'b1},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h0A, 1'b0},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h15, 1'b1},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h0A, 1'b0},
    '{ROW_CFG,  RegCounts,    64'h0,                   5'h00, 1'b0},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h15, 1'b1},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h15, 1'b1},
    '{ROW_CFG,  RegSpare5,    64'hFFFF_FFFF_FFFF_FFFF, 5'h00, 1'b0},
    '{ROW_CFG,  RegSpare7,    64'hFFFF_FFFF_FFFF_FFFF, 5'h00, 1'b0},
    '{ROW_CFG,  RegCounts,    64'h0000_0000_0001_B1E4, 5'h00, 1'b0},
    '{ROW_CFG,  RegDebounce,  64'hFFFF_FFFF_FFFF_FF02, 5'h00, 1'b0},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h0A, 1'b0},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h1F, 1'b0},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h0A, 1'b0},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h0A, 1'b0},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h0A, 1'b0},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h00, 1'b0},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h15, 1'b0},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h15, 1'b0},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h15, 1'b0},
    '{ROW_TICK, RegDebounce,  64'h0,                   5'h15, 1'b0}
  };

  multi_channel_debounce_events_top dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .pin_levels (pin_levels),
    .empty      (empty),
    .pop        (pop),
    .event_code (event_code),
    .channel    (channel),
    .went_down  (went_down),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Step every channel's debounce machine for one tick and queue the events it emits.
  function automatic int predict_tick(input logic [PinW-1:0] pins);
    int              produced;
    logic            is_pressed;
    logic [CntW-1:0] cnt;
    logic [ListW-1:0] list;
    settle_event_t   ev;
    produced = 0;
    for (int c = 0; c < NCH; c++) begin
      is_pressed = (pins[c] == model_cfg.pressed_levels[c]);
      case (chan_phase[c])
        SW_UP: begin
          if (is_pressed) begin
            chan_phase[c] = SW_FALLING;
            chan_count[c] = model_cfg.debounce_ticks;
          end
        end
        SW_DOWN: begin
          if (!is_pressed) begin
            chan_phase[c] = SW_RISING;
            chan_count[c] = model_cfg.debounce_ticks;
          end
        end
        default: begin
          if (chan_count[c] != '0) begin
            chan_count[c] = chan_count[c] - 1'b1;
          end else begin
            // settle to whatever level is seen now, even after a bounce
            cnt  = is_pressed ? model_cfg.event_counts[2*c +: CntW]
                              : model_cfg.event_counts[10 + 2*c +: CntW];
            list = is_pressed ? model_cfg.down_event_codes[ListW*c +: ListW]
                              : model_cfg.up_event_codes[ListW*c +: ListW];
            chan_phase[c] = is_pressed ? SW_DOWN : SW_UP;
            if (is_pressed) down_settles++;
            else up_settles++;
            for (int s = 0; s < MaxEvents && s < int'(cnt); s++) begin
              ev.code      = list[CodeW*s +: CodeW];
              ev.chan      = ChanW'(c);
              ev.went_down = is_pressed;
              ev.last      = 1'b0;
              expected_events.push_back(ev);
              produced++;
            end
          end
        end
      endcase
    end
    if (produced > 0) expected_events[$].last = 1'b1;
    return produced;
  endfunction

  function automatic int pick_gap(input bit eager);
    int r;
    if (eager) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic note_mismatch(input string what, input int exp_v, input int got_v);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("t=%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
  endtask

  // Offer one tick; push stays high into the next call when no gap is drawn.
  task automatic send_tick(input logic [PinW-1:0] pins, input bit eager, output int produced);
    int gap;
    gap = pick_gap(eager);
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push       <= 1'b1;
    pin_levels <= pins;
    do @(posedge clk); while (full);
    produced = predict_tick(pins);
    ticks_sent++;
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegDebounce:  model_cfg.debounce_ticks   = data[DebW-1:0];
      RegPressed:   model_cfg.pressed_levels   = data[PinW-1:0];
      RegCounts:    model_cfg.event_counts     = data[CountsW-1:0];
      RegDownCodes: model_cfg.down_event_codes = data[CodesW-1:0];
      RegUpCodes:   model_cfg.up_event_codes   = data[CodesW-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering ticks, wait for every queued event, then let the scanner finish.
  task automatic wait_drained();
    int waited;
    waited = 0;
    @(negedge clk);
    push <= 1'b0;
    while (expected_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_events.size() != 0) begin
      fail_count++;
      $display("t=%0t: %0d expected events never arrived", $time, expected_events.size());
      expected_events.delete();
    end
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic configure_phase(input int p);
    logic [CfgDataW-1:0] word;
    logic [DebW-1:0]     deb;
    wait_drained();
    if (p == 0) deb = '0;
    else if (p == RAND_PHASES - 1) deb = '1;
    else if (p == 3) deb = 8'd20;
    else deb = DebW'($urandom_range(0, 4));
    word = {$urandom, $urandom};
    word[DebW-1:0] = deb;
    cfg_write(RegDebounce, word);
    if (p == 0 || $urandom_range(0, 1)) cfg_write(RegPressed, {$urandom, $urandom});
    if (p == 2) begin
      cfg_write(RegCounts, '1);
    end else if (p == 0 || $urandom_range(0, 1)) begin
      word = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) word = '0;
      cfg_write(RegCounts, word);
    end
    if (p == 0 || $urandom_range(0, 1)) cfg_write(RegDownCodes, {$urandom, $urandom});
    if (p == 0 || $urandom_range(0, 1)) cfg_write(RegUpCodes, {$urandom, $urandom});
    if (p % 3 == 1) cfg_write(RegSpare5 + CfgIdxW'($urandom_range(0, 2)), {$urandom, $urandom});
  endtask

  // Mostly held pin patterns of random length, with some bounces and noise.
  task automatic run_phase(input int p);
    logic [PinW-1:0] held;
    logic [PinW-1:0] pins;
    int              hold_left;
    int              produced;
    int              span;
    bit              eager;
    configure_phase(p);
    held      = PinW'($urandom);
    hold_left = 0;
    eager     = (p == 2 || p == 5);
    rx_eager  = (p == 5);
    span      = (model_cfg.debounce_ticks > 6) ? 6 : int'(model_cfg.debounce_ticks);
    if (p == 2) drain_hold = 1'b1;
    for (int i = 0; i < PHASE_TICKS; i++) begin
      if (p == 4 && i == PHASE_TICKS / 2) wait_drained();
      if ($urandom_range(0, 99) < 15) begin
        pins = PinW'($urandom);
      end else begin
        if (hold_left == 0) begin
          held ^= PinW'(1 << $urandom_range(0, PinW - 1));
          if ($urandom_range(0, 1)) held ^= PinW'(1 << $urandom_range(0, PinW - 1));
          hold_left = $urandom_range(1, span + 3);
        end
        pins = held;
        hold_left--;
      end
      send_tick(pins, eager, produced);
    end
    rx_eager = 1'b0;
  endtask

  initial begin
    int produced;
    rst        = 1'b1;
    push       = 1'b0;
    pin_levels = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    model_cfg  = '{debounce_ticks: DebounceReset, pressed_levels: '0,
                   event_counts: CountsReset, down_event_codes: '0, up_event_codes: '0};
    for (int c = 0; c < NCH; c++) begin
      chan_phase[c] = SW_UP;
      chan_count[c] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) begin
        wait_drained();
        cfg_write(dir_table[i].idx, dir_table[i].data);
      end else begin
        send_tick(dir_table[i].pins, 1'b0, produced);
        if (dir_table[i].quiet && produced != 0)
          note_mismatch("quiet tick event count", 0, produced);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) run_phase(p);

    wait_drained();
    $display("Ran %0d ticks over %0d register writes; checked %0d events",
             ticks_sent, cfg_writes, events_seen);
    $display("Channels settled pressed %0d times and released %0d times",
             down_settles, up_settles);
    if (fail_count == 0) begin
      $display("multi_channel_debounce_events_top test passed");
    end else begin
      $display("multi_channel_debounce_events_top test failed");
    end
    $finish;
  end

  // Event sink: random pop gaps and bursts, plus one long hold to back up the block.
  initial begin
    int gap;
    pop = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (drain_hold) begin
        pop <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        drain_hold = 1'b0;
      end else begin
        gap = pick_gap(rx_eager);
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        pop <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    settle_event_t want;
    if (!rst && pop && !empty) begin
      events_seen++;
      if (expected_events.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("t=%0t: event transfer with nothing expected, actual code %0d channel %0d",
                   $time, event_code, channel);
      end else begin
        want = expected_events.pop_front();
        if (event_code !== want.code) note_mismatch("event_code", want.code, event_code);
        if (channel !== want.chan) note_mismatch("channel", want.chan, channel);
        if (went_down !== want.went_down) note_mismatch("went_down", want.went_down, went_down);
        if (last !== want.last) note_mismatch("last", want.last, last);
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("multi_channel_debounce_events_top test failed");
    $finish;
  end

endmodule

>>> files.f
rtl/dbe_pkg.sv
rtl/dbe_fifo.sv
rtl/dbe_front.sv
rtl/dbe_back.sv
rtl/multi_channel_debounce_events_top.sv
rtl/dbe_checker.sv
verif/multi_channel_debounce_events_top_tb.sv
